FILE: hdl/src_pkg.sv
// Shared types and constants for the sector request chunker.
`default_nettype none
package src_pkg;

	localparam int unsigned SECTOR_BYTES = 512;
	localparam int unsigned SECTOR_SHIFT = 9;
	localparam int unsigned MAX_SECTORS  = 4096;
	localparam int unsigned MAX_RESULTS  = 64;

	localparam int unsigned BS_W   = 21;
	localparam int unsigned LBA_W  = 32;
	localparam int unsigned CNT_W  = 13;
	localparam int unsigned PB_W   = 8;
	localparam int unsigned OFF_W  = 11;
	localparam int unsigned FACT_W = BS_W - SECTOR_SHIFT;
	localparam int unsigned DIV_DW = LBA_W + 1;
	localparam int unsigned DIV_CW = 6;
	localparam int unsigned SPAN_W = 14;

	typedef enum logic [1:0] {
		ST_CHUNK   = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_TOO_BIG = 2'd2
	} status_t;

	typedef struct packed {
		logic              start;
		logic [DIV_CW-1:0] nbits;
	} div_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/src_if.sv
// Request and result channel interfaces.
`default_nettype none
interface src_req_if import src_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [LBA_W-1:0] start_sector;
	logic [CNT_W-1:0] sector_count;

	modport source (output valid, req_type, start_sector, sector_count, input ready);
	modport sink (input valid, req_type, start_sector, sector_count, output ready);
endinterface

interface src_res_if import src_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [LBA_W-1:0] phys_block;
	logic [PB_W-1:0]  phys_blocks;
	logic [OFF_W-1:0] sector_offset;
	logic [PB_W-1:0]  chunk_len;
	logic [CNT_W-1:0] buffer_sector;
	logic             needs_preread;
	logic             last;

	modport source (output valid, status, phys_block, phys_blocks, sector_offset,
		chunk_len, buffer_sector, needs_preread, last, input ready);
	modport sink (input valid, status, phys_block, phys_blocks, sector_offset,
		chunk_len, buffer_sector, needs_preread, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/src_div.sv
// Restoring divider, one quotient bit per cycle, by the block factor.
`default_nettype none
module src_div import src_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_cmd_t          cmd,
	input  logic [DIV_DW-1:0] dividend,
	input  logic [FACT_W-1:0] divisor,
	output logic              done,
	output logic [DIV_DW-1:0] quo,
	output logic [FACT_W-1:0] rem
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] quo_q;
	logic [FACT_W-1:0] rem_q;

	logic [FACT_W:0]   part;
	logic [FACT_W:0]   diff;
	logic              ge;
	logic [FACT_W-1:0] rem_nx;
	logic [DIV_CW-1:0] shamt;

	always_comb begin
		part   = {rem_q, quo_q[DIV_DW-1]};
		diff   = part - {1'b0, divisor};
		ge     = part >= {1'b0, divisor};
		rem_nx = ge ? diff[FACT_W-1:0] : part[FACT_W-1:0];
		// left-align the dividend so only nbits iterations are needed
		shamt  = DIV_CW'(DIV_DW) - cmd.nbits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CW'(1));
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= dividend << shamt;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_DW-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

FILE: hdl/sector_request_chunker.sv
// Top level: splits sector requests into bounce-buffer sized block commands.
// A request is taken only when idle. An empty request yields its result directly; a
// chunk follows three divisions on the shared divider (one quotient bit per cycle) by the
// block factor: buffer sectors, start sector, chunk span. Later chunks need only the span.
// ready returns the cycle after the last result, or the MAX_RESULTS-th, is taken.
// arst_n clears the sequencer and held request; the block-size register resets to 512.
`default_nettype none
module sector_request_chunker import src_pkg::*; #(
	parameter int unsigned BOUNCE_BYTES = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [BS_W-1:0] cfg_wdata,
	src_req_if.sink         req,
	src_res_if.source       res
);

	localparam int unsigned BS_SECT = BOUNCE_BYTES / SECTOR_BYTES;
	localparam int unsigned MPB_W   = $clog2(BS_SECT + 1);
	localparam int unsigned NRES_W  = $clog2(MAX_RESULTS);
	localparam int unsigned AW      = 16;
	localparam logic [MPB_W-1:0] BS_SECT_V = MPB_W'(BS_SECT);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIVB = 5'b00010,
		S_DIVC = 5'b00100,
		S_DIVS = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [BS_W-1:0]   bs_q;
	logic [CNT_W-1:0]  done_q;
	logic [CNT_W-1:0]  count_q;
	logic [LBA_W-1:0]  start_q;
	logic              is_wr_q;
	logic [NRES_W-1:0] nres_q;
	logic [MPB_W-1:0]  maxpb_q;
	logic [MPB_W-1:0]  cap_q;
	logic [DIV_DW-1:0] plba_q;
	logic [FACT_W-1:0] off_q;
	logic [CNT_W-1:0]  chunk_q;
	logic [CNT_W-1:0]  pcount_q;

	status_t           o_status_q;
	logic [LBA_W-1:0]  o_pb_q;
	logic [PB_W-1:0]   o_pbs_q;
	logic [OFF_W-1:0]  o_off_q;
	logic [PB_W-1:0]   o_cs_q;
	logic [CNT_W-1:0]  o_bs_q;
	logic              o_pre_q;
	logic              o_last_q;

	div_cmd_t          div_cmd;
	logic [DIV_DW-1:0] div_dividend;
	logic              div_done;
	logic [DIV_DW-1:0] div_quo;
	logic [FACT_W-1:0] div_rem;

	logic [FACT_W-1:0] fact_raw;
	logic [FACT_W-1:0] factor;
	logic [CNT_W-1:0]  remain;
	logic [DIV_DW-1:0] cur;
	logic              req_acc;
	logic              res_acc;
	logic              pending;
	logic [CNT_W-1:0]  cnt_sat;
	logic              maxpb_zero;

	logic [AW-1:0]     span;
	logic              e_clip;
	logic [AW-1:0]     e_pcount;
	logic [AW-1:0]     e_raw;
	logic [AW-1:0]     e_chunk;
	logic [AW-1:0]     e_pcf;
	logic              e_pre;
	logic              e_last;
	logic [CNT_W-1:0]  next_done;
	logic [CNT_W-1:0]  next_rem;

	always_comb begin
		fact_raw   = bs_q[BS_W-1:SECTOR_SHIFT];
		factor     = (fact_raw == '0) ? FACT_W'(1) : fact_raw;
		remain     = count_q - done_q;
		cur        = {1'b0, start_q} + DIV_DW'(done_q);
		req_acc    = req.valid && req.ready;
		res_acc    = res.valid && res.ready;
		pending    = done_q < count_q;
		cnt_sat    = (req.sector_count > CNT_W'(MAX_SECTORS)) ? CNT_W'(MAX_SECTORS)
			: req.sector_count;
		maxpb_zero = div_quo[MPB_W-1:0] == '0;
		next_done  = done_q + chunk_q;
		next_rem   = count_q - next_done;
	end

	// chunk result from the span quotient (off + remain - 1) / factor
	always_comb begin
		span     = AW'(div_quo[SPAN_W-1:0]);
		e_clip   = span >= AW'(maxpb_q);
		e_raw    = AW'(cap_q) - AW'(off_q);
		if (e_clip) begin
			e_pcount = AW'(maxpb_q);
			e_chunk  = (e_raw > AW'(remain)) ? AW'(remain) : e_raw;
			e_pcf    = AW'(cap_q);
		end else begin
			e_pcount = span + AW'(1);
			e_chunk  = AW'(remain);
			e_pcf    = AW'(off_q) + AW'(remain) + AW'(factor) - AW'(div_rem) - AW'(1);
		end
		e_pre  = is_wr_q && (factor != FACT_W'(1)) && ((off_q != '0) || (e_chunk < e_pcf));
		e_last = e_chunk >= AW'(remain);
	end

	always_comb begin
		div_cmd.start = 1'b0;
		div_cmd.nbits = DIV_CW'(SPAN_W);
		div_dividend  = '0;
		unique case (state_q)
			S_IDLE: begin
				div_cmd.nbits = DIV_CW'(MPB_W);
				div_dividend  = DIV_DW'(BS_SECT_V);
				div_cmd.start = req_acc && (pending || (cnt_sat != '0));
			end
			S_DIVB: begin
				div_cmd.nbits = DIV_CW'(DIV_DW);
				div_dividend  = cur;
				div_cmd.start = div_done && !maxpb_zero;
			end
			S_DIVC: begin
				div_dividend  = DIV_DW'(AW'(div_rem) + AW'(remain) - AW'(1));
				div_cmd.start = div_done;
			end
			S_DIVS: begin
				div_cmd.start = 1'b0;
			end
			S_OUT: begin
				div_dividend  = DIV_DW'(AW'(next_rem) - AW'(1));
				div_cmd.start = res_acc && !o_last_q && (nres_q != NRES_W'(MAX_RESULTS - 1));
			end
			default: begin
				div_cmd.start = 1'b0;
			end
		endcase
	end

	src_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (div_cmd),
		.dividend (div_dividend),
		.divisor  (factor),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bs_q    <= BS_W'(SECTOR_BYTES);
			done_q  <= '0;
			count_q <= '0;
			start_q <= '0;
			is_wr_q <= 1'b0;
			nres_q  <= '0;
		end else begin
			if (cfg_we) begin
				bs_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						nres_q <= '0;
						if (pending) begin
							state_q <= S_DIVB;
						end else if (cnt_sat == '0) begin
							state_q <= S_OUT;
						end else begin
							start_q <= req.start_sector;
							is_wr_q <= req.req_type;
							count_q <= cnt_sat;
							done_q  <= '0;
							state_q <= S_DIVB;
						end
					end
				end
				S_DIVB: begin
					if (div_done) begin
						state_q <= maxpb_zero ? S_OUT : S_DIVC;
					end
				end
				S_DIVC: begin
					if (div_done) begin
						state_q <= S_DIVS;
					end
				end
				S_DIVS: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_acc) begin
						if (o_last_q) begin
							// drop the held request
							done_q  <= '0;
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							done_q  <= next_done;
							nres_q  <= nres_q + NRES_W'(1);
							state_q <= (nres_q == NRES_W'(MAX_RESULTS - 1)) ? S_IDLE : S_DIVS;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_DIVB && div_done) begin
			maxpb_q <= div_quo[MPB_W-1:0];
			cap_q   <= BS_SECT_V - div_rem[MPB_W-1:0];
		end
		if (state_q == S_DIVC && div_done) begin
			plba_q <= div_quo;
			off_q  <= div_rem;
		end else if (state_q == S_OUT && res_acc) begin
			// a clipped chunk ends on a block boundary
			plba_q <= plba_q + DIV_DW'(pcount_q);
			off_q  <= '0;
		end
		if (state_q == S_DIVS && div_done) begin
			chunk_q  <= e_chunk[CNT_W-1:0];
			pcount_q <= e_pcount[CNT_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		priority if (state_q == S_IDLE && req_acc && !pending && cnt_sat == '0) begin
			o_status_q <= ST_EMPTY;
			o_pb_q     <= '0;
			o_pbs_q    <= '0;
			o_off_q    <= '0;
			o_cs_q     <= '0;
			o_bs_q     <= '0;
			o_pre_q    <= 1'b0;
			o_last_q   <= 1'b1;
		end else if (state_q == S_DIVB && div_done && maxpb_zero) begin
			o_status_q <= ST_TOO_BIG;
			o_pb_q     <= '0;
			o_pbs_q    <= '0;
			o_off_q    <= '0;
			o_cs_q     <= '0;
			o_bs_q     <= done_q;
			o_pre_q    <= 1'b0;
			o_last_q   <= 1'b1;
		end else if (state_q == S_DIVS && div_done) begin
			o_status_q <= ST_CHUNK;
			o_pb_q     <= plba_q[LBA_W-1:0];
			o_pbs_q    <= e_pcount[PB_W-1:0];
			o_off_q    <= off_q[OFF_W-1:0];
			o_cs_q     <= e_chunk[PB_W-1:0];
			o_bs_q     <= done_q;
			o_pre_q    <= e_pre;
			o_last_q   <= e_last;
		end else begin
			o_last_q <= o_last_q;
		end
	end

	assign req.ready         = state_q == S_IDLE;
	assign res.valid         = state_q == S_OUT;
	assign res.status        = o_status_q;
	assign res.phys_block    = o_pb_q;
	assign res.phys_blocks   = o_pbs_q;
	assign res.sector_offset = o_off_q;
	assign res.chunk_len     = o_cs_q;
	assign res.buffer_sector = o_bs_q;
	assign res.needs_preread = o_pre_q;
	assign res.last          = o_last_q;

endmodule
`default_nettype wire

FILE: hdl/src_chk.sv
// Port-level checker for the sector request chunker, with its bind.
`default_nettype none
module src_chk import src_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             res_valid,
	input logic             res_ready,
	input logic [1:0]       status,
	input logic [LBA_W-1:0] phys_block,
	input logic [PB_W-1:0]  phys_blocks,
	input logic [OFF_W-1:0] sector_offset,
	input logic [PB_W-1:0]  chunk_len,
	input logic [CNT_W-1:0] buffer_sector,
	input logic             needs_preread,
	input logic             last
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && res_valid))
		else $error("request taken while a result waits");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready right after a request was taken");

	a_special_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_CHUNK |-> last && phys_block == '0
			&& phys_blocks == '0 && sector_offset == '0 && chunk_len == '0
			&& !needs_preread)
		else $error("empty or error result not final or not cleared");

	a_empty_buf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_EMPTY |-> buffer_sector == '0)
		else $error("empty result with nonzero buffer position");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status)
			&& $stable(buffer_sector) && $stable(last))
		else $error("stalled result changed");

endmodule

bind sector_request_chunker src_chk u_src_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.status        (res.status),
	.phys_block    (res.phys_block),
	.phys_blocks   (res.phys_blocks),
	.sector_offset (res.sector_offset),
	.chunk_len     (res.chunk_len),
	.buffer_sector (res.buffer_sector),
	.needs_preread (res.needs_preread),
	.last          (res.last)
);
`default_nettype wire
